[sv/rast_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rast_pkg
// Types and constants shared by the ray/box slab test pipeline.
// ----------------------------------------------------------------------------
package rast_pkg;

  localparam int FRAC_BITS = 16;
  localparam int REM_W     = 32 + FRAC_BITS;
  localparam int DIV_W     = REM_W + 32;
  localparam int QBITS     = 32;
  localparam int NLANE     = 6;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  typedef enum logic [2:0] {
    REG_ORIGIN_X  = 3'd0,
    REG_ORIGIN_Y  = 3'd1,
    REG_ORIGIN_Z  = 3'd2,
    REG_DIR_X     = 3'd3,
    REG_DIR_Y     = 3'd4,
    REG_DIR_Z     = 3'd5,
    REG_THRESHOLD = 3'd6,
    REG_UNUSED    = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] box_min_x;
    logic signed [31:0] box_min_y;
    logic signed [31:0] box_min_z;
    logic signed [31:0] box_max_x;
    logic signed [31:0] box_max_y;
    logic signed [31:0] box_max_z;
    logic               last_box;
  } box_in_t;

  typedef struct packed {
    logic        hit;
    logic [30:0] entry_distance;
    logic        last_result;
  } box_out_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [31:0]      dv;
    logic [QBITS-1:0] q;
    logic             neg;
    logic             ovf;
  } lane_t;

  typedef struct packed {
    lane_t [NLANE-1:0] lane;
    logic  [2:0]       par;
    logic              rej;
    logic              last;
  } flight_t;

  typedef struct packed {
    logic signed [NLANE-1:0][31:0] t;
    logic [2:0] par;
    logic       rej;
    logic       last;
  } quot_t;

  typedef struct packed {
    logic signed [2:0][31:0] a;
    logic signed [2:0][31:0] b;
    logic       rej;
    logic       last;
  } bound_t;

endpackage

[sv/ray_aabb_slab_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_aabb_slab_test
// Slab test of one ray against a stream of boxes, fixed-point quotients.
// ----------------------------------------------------------------------------
// Register order: input, setup, divide stages, quotient, slab bounds, result.
// Throughput: one box word per cycle while out_ready does not stall; 32
//   restoring divide stages, one quotient bit each, six lanes, set the depth.
// Reset: synchronous active-low rst_n clears valid bits and loads ray
//   registers with origin 0, direction +x, threshold 1.
module ray_aabb_slab_test
  import rast_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  box_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output box_out_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  reg_idx_t    cfg_index,
  input  logic [31:0] cfg_data
);

  logic signed [2:0][31:0] org_r, dir_r;
  logic [15:0]             thr_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_r <= '0;
      dir_r <= {32'sd0, 32'sd0, 32'sd65536};
      thr_r <= 16'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ORIGIN_X:  org_r[0] <= cfg_data;
        REG_ORIGIN_Y:  org_r[1] <= cfg_data;
        REG_ORIGIN_Z:  org_r[2] <= cfg_data;
        REG_DIR_X:     dir_r[0] <= cfg_data;
        REG_DIR_Y:     dir_r[1] <= cfg_data;
        REG_DIR_Z:     dir_r[2] <= cfg_data;
        REG_THRESHOLD: thr_r    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  logic adv;
  logic out_valid_r;
  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = adv;
  assign out_valid = out_valid_r;

  // input register
  box_in_t in_r;
  logic    in_v_r;
  always_ff @(posedge clk) begin
    if (!rst_n) in_v_r <= 1'b0;
    else if (adv) in_v_r <= in_valid;
    if (adv) in_r <= in_data;
  end

  // setup: differences, magnitudes, parallel check
  flight_t pipe_r [0:QBITS];
  logic    pv_r   [0:QBITS];
  flight_t setup_nxt;

  always_comb begin
    logic signed [31:0] lo [3];
    logic signed [31:0] hi [3];
    logic signed [31:0] org;
    logic [31:0]        mag;
    logic signed [32:0] df;
    logic [31:0]        dm;
    logic [REM_W-1:0]   rm;
    lo[0] = in_r.box_min_x; lo[1] = in_r.box_min_y; lo[2] = in_r.box_min_z;
    hi[0] = in_r.box_max_x; hi[1] = in_r.box_max_y; hi[2] = in_r.box_max_z;
    setup_nxt      = '0;
    setup_nxt.last = in_r.last_box;
    for (int i = 0; i < 3; i++) begin
      org = org_r[i];
      mag = dir_r[i][31] ? 32'(-dir_r[i]) : dir_r[i];
      setup_nxt.par[i] = (mag <= {16'd0, thr_r});
      if (setup_nxt.par[i] && (org < lo[i] || org > hi[i]))
        setup_nxt.rej = 1'b1;
      for (int j = 0; j < 2; j++) begin
        df = j == 0 ? (33'(lo[i]) - 33'(org)) : (33'(hi[i]) - 33'(org));
        dm = df[32] ? 32'(-df) : df[31:0];
        rm = {dm, {FRAC_BITS{1'b0}}};
        setup_nxt.lane[2*i+j].rem = rm;
        setup_nxt.lane[2*i+j].dv  = mag;
        setup_nxt.lane[2*i+j].q   = '0;
        setup_nxt.lane[2*i+j].neg = df[32] ^ dir_r[i][31];
        setup_nxt.lane[2*i+j].ovf = (DIV_W'(rm) >= (DIV_W'(mag) << 32));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) pv_r[0] <= 1'b0;
    else if (adv) pv_r[0] <= in_v_r;
    if (adv) pipe_r[0] <= setup_nxt;
  end

  // restoring divide: one quotient bit per stage
  for (genvar s = 0; s < QBITS; s++) begin : g_div
    flight_t div_nxt;
    always_comb begin
      logic [DIV_W-1:0] rx, dsh;
      div_nxt = pipe_r[s];
      for (int l = 0; l < NLANE; l++) begin
        rx  = DIV_W'(pipe_r[s].lane[l].rem);
        dsh = DIV_W'(pipe_r[s].lane[l].dv) << (QBITS - 1 - s);
        if (rx >= dsh) begin
          div_nxt.lane[l].rem = REM_W'(rx - dsh);
          div_nxt.lane[l].q[QBITS-1-s] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) pv_r[s+1] <= 1'b0;
      else if (adv) pv_r[s+1] <= pv_r[s];
      if (adv) pipe_r[s+1] <= div_nxt;
    end
  end

  // sign and saturate
  quot_t quot_r, quot_nxt;
  logic  quot_v_r;
  always_comb begin
    lane_t ln;
    quot_nxt.par  = pipe_r[QBITS].par;
    quot_nxt.rej  = pipe_r[QBITS].rej;
    quot_nxt.last = pipe_r[QBITS].last;
    for (int l = 0; l < NLANE; l++) begin
      ln = pipe_r[QBITS].lane[l];
      if (ln.neg)
        quot_nxt.t[l] = (ln.ovf || ln.q > 32'h8000_0000) ? Q_MIN : 32'(-ln.q);
      else
        quot_nxt.t[l] = (ln.ovf || ln.q[31]) ? Q_MAX : ln.q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) quot_v_r <= 1'b0;
    else if (adv) quot_v_r <= pv_r[QBITS];
    if (adv) quot_r <= quot_nxt;
  end

  // order each slab; a parallel axis gets the range 0 to Q_MAX
  bound_t bnd_r, bnd_nxt;
  logic   bnd_v_r;
  always_comb begin
    logic signed [31:0] t1, t2;
    bnd_nxt.rej  = quot_r.rej;
    bnd_nxt.last = quot_r.last;
    for (int i = 0; i < 3; i++) begin
      t1 = quot_r.t[2*i];
      t2 = quot_r.t[2*i+1];
      if (quot_r.par[i]) begin
        bnd_nxt.a[i] = 32'sd0;
        bnd_nxt.b[i] = Q_MAX;
      end else begin
        bnd_nxt.a[i] = (t1 < t2) ? t1 : t2;
        bnd_nxt.b[i] = (t1 < t2) ? t2 : t1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) bnd_v_r <= 1'b0;
    else if (adv) bnd_v_r <= quot_v_r;
    if (adv) bnd_r <= bnd_nxt;
  end

  // combine axes
  box_out_t out_r, out_nxt;
  always_comb begin
    logic signed [31:0] tmin, tmax;
    logic               h;
    tmin = 32'sd0;
    tmax = Q_MAX;
    for (int i = 0; i < 3; i++) begin
      if ($signed(bnd_r.a[i]) > tmin) tmin = bnd_r.a[i];
      if ($signed(bnd_r.b[i]) < tmax) tmax = bnd_r.b[i];
    end
    h = !bnd_r.rej && (tmax >= tmin) && !tmax[31];
    out_nxt.hit            = h;
    out_nxt.entry_distance = h ? tmin[30:0] : 31'd0;
    out_nxt.last_result    = bnd_r.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (adv) out_valid_r <= bnd_v_r;
    if (adv) out_r <= out_nxt;
  end

  assign out_data = out_r;

endmodule

[sv/rast_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rast_checker
// Port-level checks on the slab test result channel.
// ----------------------------------------------------------------------------
module rast_checker
  import rast_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     out_valid,
  input logic     out_ready,
  input box_out_t out_data
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word dropped or changed while stalled");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit |-> out_data.entry_distance == 31'd0)
    else $error("miss with nonzero entry distance");

  a_reset: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind ray_aabb_slab_test rast_checker u_rast_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Streams boxes through the slab test against a configured ray that is set
// anew between groups of boxes. A directed table is run first, then random
// rays and boxes. Each result word is compared in order with a local
// prediction of hit, entry distance and last flag.
// ----------------------------------------------------------------------------
module tb_top;
  import rast_pkg::*;

  localparam int LATENCY = 36;
  localparam int N_RAND  = 1650;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  box_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  box_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  reg_idx_t cfg_index = REG_ORIGIN_X;
  logic [31:0] cfg_data = '0;

  ray_aabb_slab_test dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  logic signed [31:0] ray_org [3];
  logic signed [31:0] ray_dir [3];
  logic [15:0] par_thresh;

  box_out_t pending_hits [$];
  int mismatches = 0;
  bit run_done = 1'b0;

  typedef struct {
    box_in_t  box;
    bit       known;
    box_out_t res;
  } box_row_t;

  function automatic logic signed [63:0] clamp_q(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic box_out_t slab_result(box_in_t b);
    logic signed [63:0] tmin, tmax, lo, hi, org, d, mag, t1, t2, a, c;
    logic signed [31:0] los [3], his [3];
    bit ok;
    box_out_t r;
    los = '{b.box_min_x, b.box_min_y, b.box_min_z};
    his = '{b.box_max_x, b.box_max_y, b.box_max_z};
    tmin = 0;
    tmax = 64'sd2147483647;
    ok = 1'b1;
    for (int k = 0; k < 3; k++) begin
      org = ray_org[k];
      d = ray_dir[k];
      lo = los[k];
      hi = his[k];
      mag = d < 0 ? -d : d;
      if (mag <= $signed({48'd0, par_thresh})) begin
        if (org < lo || org > hi) ok = 1'b0;
      end else begin
        t1 = clamp_q(((lo - org) <<< FRAC_BITS) / d);
        t2 = clamp_q(((hi - org) <<< FRAC_BITS) / d);
        a = t1 < t2 ? t1 : t2;
        c = t1 < t2 ? t2 : t1;
        if (a > tmin) tmin = a;
        if (c < tmax) tmax = c;
      end
    end
    r.hit = ok && tmax >= tmin && tmax >= 0;
    r.entry_distance = r.hit ? tmin[30:0] : '0;
    r.last_result = b.last_box;
    return r;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 3) != 0) return 0;
    if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return $urandom;
      default: return $signed($urandom_range(0, 40 << 16)) - (20 << 16);
    endcase
  endfunction

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ORIGIN_X, REG_ORIGIN_Y, REG_ORIGIN_Z: ray_org[idx] = val;
      REG_DIR_X: ray_dir[0] = val;
      REG_DIR_Y: ray_dir[1] = val;
      REG_DIR_Z: ray_dir[2] = val;
      REG_THRESHOLD: par_thresh = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_ray(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                         logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
                         logic [15:0] th);
    in_valid <= 1'b0;
    while (pending_hits.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_ORIGIN_Z, oz);
    write_reg(REG_DIR_X, dx);
    write_reg(REG_DIR_Y, dy);
    write_reg(REG_DIR_Z, dz);
    write_reg(REG_THRESHOLD, {16'd0, th});
  endtask

  task automatic send_box(box_in_t b, bit known, box_out_t res);
    box_out_t p;
    int g;
    p = slab_result(b);
    if (known && p != res) begin
      mismatches++;
      if (mismatches <= 10)
        $display("table row disagrees: box %h table %h calc %h", b, res, p);
    end
    in_data  <= b;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_hits.push_back(p);
    @(negedge clk);
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  task automatic run_table();
    box_row_t rows [$];
    box_row_t r;
    box_out_t miss;
    miss = '{hit: 1'b0, entry_distance: '0, last_result: 1'b0};
    // reset ray: origin 0, +x, threshold 1
    r.known = 1; r.box = '{32'sh0001_0000, -1, -1, 32'sh0002_0000, 1, 1, 1'b0};
    r.res = '{1'b1, 31'h0001_0000, 1'b0}; rows.push_back(r);
    r.box = '{-32'sh0001_0000, -1, -1, 32'sh0001_0000, 1, 1, 1'b1};
    r.res = '{1'b1, 31'd0, 1'b1}; rows.push_back(r);
    r.box = '{32'sh0001_0000, 5, -1, 32'sh0002_0000, 6, 1, 1'b0};
    r.res = miss; rows.push_back(r);
    r.box = '{-32'sh0003_0000, -1, -1, -32'sh0002_0000, 1, 1, 1'b0};
    r.res = miss; rows.push_back(r);
    r.box = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
              32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1};
    r.res = '{1'b1, 31'd0, 1'b1}; rows.push_back(r);
    r.known = 0;
    r.box = '{32'sh0002_0000, -1, -1, 32'sh0001_0000, 1, 1, 1'b0}; rows.push_back(r);
    r.box = '{32'sh7FFF_FFFF, 0, 0, 32'sh7FFF_FFFF, 0, 0, 1'b0}; rows.push_back(r);
    r.box = '{-32'sh7FFF_FFFF, 0, 0, 32'sh8000_0000, 0, 0, 1'b1}; rows.push_back(r);
    foreach (rows[i]) send_box(rows[i].box, rows[i].known, rows[i].res);
    set_ray(32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h8000_0000, 1, 32'h7FFF_FFFF, 16'hFFFF);
    for (int i = 0; i < 8; i++) begin
      r.box = '{rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                rand_coord(), rand_coord(), 1'($urandom)};
      send_box(r.box, 0, miss);
    end
    set_ray(32'hFFFF_0000, 0, 32'h0000_8000, 32'h0000_B504, 32'h0000_B504, 2, 16'd0);
    for (int i = 0; i < 8; i++) begin
      r.box = '{rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                rand_coord(), rand_coord(), 1'($urandom)};
      send_box(r.box, 0, miss);
    end
  endtask

  task automatic run_random();
    box_in_t b;
    box_out_t none;
    logic signed [31:0] lo, hi;
    logic [31:0] dv [3];
    none = '0;
    for (int i = 0; i < N_RAND; i++) begin
      if (i % 150 == 0) begin
        for (int k = 0; k < 3; k++)
          case ($urandom_range(0, 4))
            0: dv[k] = 32'h8000_0000;
            1: dv[k] = $urandom_range(0, 3) - 1;
            2: dv[k] = $urandom;
            default: dv[k] = $signed($urandom_range(0, 1 << 17)) - (1 << 16);
          endcase
        set_ray(rand_coord(), rand_coord(), rand_coord(), dv[0], dv[1], dv[2],
                $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 4)));
      end
      if ($urandom_range(0, 4) == 0) begin
        b = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 1'($urandom)};
      end else begin
        for (int k = 0; k < 3; k++) begin
          lo = $signed(ray_org[k]) + ($signed($urandom_range(0, 20 << 16)) - (10 << 16));
          hi = lo + $urandom_range(0, 8 << 16);
          if ($urandom_range(0, 15) == 0) hi = lo - $urandom_range(1, 1000);
          case (k)
            0: begin b.box_min_x = lo; b.box_max_x = hi; end
            1: begin b.box_min_y = lo; b.box_max_y = hi; end
            default: begin b.box_min_z = lo; b.box_max_z = hi; end
          endcase
        end
        b.last_box = $urandom;
      end
      send_box(b, 0, none);
    end
  endtask

  initial begin
    ray_org = '{0, 0, 0};
    ray_dir = '{32'sh0001_0000, 0, 0};
    par_thresh = 16'd1;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    run_table();
    run_random();
    in_valid <= 1'b0;
    while (pending_hits.size() != 0) @(negedge clk);
    repeat (LATENCY + 8) @(negedge clk);
    run_done = 1'b1;
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  int stall = 0;
  always @(negedge clk) begin
    if (!run_done) begin
      if (stall > 0) begin
        stall <= stall - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        stall <= gap_len();
      end
    end
  end

  always @(posedge clk) begin
    box_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", out_data);
      end else begin
        want = pending_hits.pop_front();
        if (out_data.hit !== want.hit || out_data.entry_distance !== want.entry_distance ||
            out_data.last_result !== want.last_result) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: hit %b/%b dist %h/%h last %b/%b (exp/act)",
                     want.hit, out_data.hit, want.entry_distance, out_data.entry_distance,
                     want.last_result, out_data.last_result);
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
